@@ rtl/core/bbde_pkg.sv @@
package bbde_pkg;

    localparam int COORD_W = 13;
    localparam int IMG_W   = 13;
    localparam int FOV_W   = 16;
    localparam int DIST_W  = 24;
    localparam int ANG_W   = 16;

    // shared divider: numerator width covers every quotient, divisor 32 bits
    localparam int DIV_N = 48;
    localparam int DIV_D = 32;

    localparam logic [14:0] ANG_CLAMP = 15'd25735;
    localparam logic [14:0] ANG_SAT   = 15'd32767;
    localparam int          CORD_STEPS = 15;

    localparam logic [2:0] REG_OBJECT_WIDTH  = 3'd0;
    localparam logic [2:0] REG_OBJECT_HEIGHT = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_FOV_H         = 3'd4;
    localparam logic [2:0] REG_FOV_V         = 3'd5;
    localparam logic [2:0] REG_FOCAL         = 3'd6;

    localparam logic [1:0] METHOD_AGREE  = 2'd0;
    localparam logic [1:0] METHOD_BORDER = 2'd1;
    localparam logic [1:0] METHOD_LARGER = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] corner_a_x;
        logic [COORD_W-1:0] corner_a_y;
        logic [COORD_W-1:0] corner_b_x;
        logic [COORD_W-1:0] corner_b_y;
    } bbde_in_t;

    typedef struct packed {
        logic [DIST_W-1:0]       distance;
        logic                    out_of_range;
        logic                    degenerate;
        logic [1:0]              method;
        logic signed [ANG_W-1:0] right_edge_angle;
        logic signed [ANG_W-1:0] left_edge_angle;
    } bbde_out_t;

    // arctangent of 2^-i in Q2.14
    function automatic logic signed [15:0] atan_q14(input logic [3:0] i);
        logic signed [15:0] r;
        case (i)
            4'd0:    r = 16'sd12868;
            4'd1:    r = 16'sd7596;
            4'd2:    r = 16'sd4014;
            4'd3:    r = 16'sd2037;
            4'd4:    r = 16'sd1023;
            4'd5:    r = 16'sd512;
            4'd6:    r = 16'sd256;
            4'd7:    r = 16'sd128;
            4'd8:    r = 16'sd64;
            4'd9:    r = 16'sd32;
            4'd10:   r = 16'sd16;
            4'd11:   r = 16'sd8;
            4'd12:   r = 16'sd4;
            4'd13:   r = 16'sd2;
            4'd14:   r = 16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/bounding_box_depth_estimator.sv @@
// The shared 48-step restoring divider (up to ten divisions) and 15 CORDIC steps per
//   axis do the work; a zero image size goes from the input beat straight to the
//   result.
// A new box is taken only while idle, once the last result is handed to the output
//   register; a finished result waits there while the next box is taken.
// Reset: synchronous, active-low aresetn; control and config registers take defaults, kept estimate clears.
module bounding_box_depth_estimator #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bbde_pkg::bbde_in_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bbde_pkg::bbde_out_t   m_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [LENGTH_BITS-1:0] cfg_wdata
);

    localparam int LB = LENGTH_BITS;
    localparam int CW = bbde_pkg::COORD_W;
    localparam int DN = bbde_pkg::DIV_N;
    localparam int DD = bbde_pkg::DIV_D;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EMUL   = 4'd1;
    localparam logic [3:0] S_ELOAD  = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_XMUL   = 4'd5;
    localparam logic [3:0] S_XLOAD  = 4'd6;
    localparam logic [3:0] S_CORD   = 4'd7;
    localparam logic [3:0] S_TANCHK = 4'd8;
    localparam logic [3:0] S_QLOAD  = 4'd9;
    localparam logic [3:0] S_DECIDE = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    localparam logic [1:0] OP_EDGE = 2'd0;
    localparam logic [1:0] OP_X1   = 2'd1;
    localparam logic [1:0] OP_TAN  = 2'd2;
    localparam logic [1:0] OP_Q    = 2'd3;

    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
    localparam logic [63:0]   RANGE_LIMIT = 64'd204800;

    // configuration
    logic [LB-1:0] obj_w_reg, obj_h_reg, focal_reg;
    logic [bbde_pkg::IMG_W-1:0] img_w_reg, img_h_reg;
    logic [bbde_pkg::FOV_W-1:0] fov_h_reg, fov_v_reg;

    logic [3:0]    state_reg;
    logic          m_valid_reg;
    logic [LB-1:0] last_est_reg;
    bbde_pkg::bbde_out_t m_data_reg;

    // item working set
    logic [CW-1:0] xmax_reg, xmin_reg, ymax_reg, ymin_reg;
    logic [LB-1:0] len_x_reg, len_y_reg;
    logic [1:0]    edge_idx_reg;
    logic          axis_reg;
    logic [1:0]    op_reg;
    logic [14:0]   axmax_reg, axmin_reg, aymax_reg, aymin_reg;
    logic signed [15:0] right_reg, left_reg;
    logic          neg_reg;
    logic [47:0]   prod_reg;
    logic [LB-1:0] x1_reg, dx_reg, dy_reg, dist_reg;
    logic [31:0]   tan_reg;
    logic          degen_reg, upd_reg;
    logic [1:0]    method_reg;

    // shared divider
    logic [DN-1:0] dv_quo_reg;
    logic [DD-1:0] dv_rem_reg, dv_den_reg;
    logic [5:0]    dv_cnt_reg;

    // CORDIC rotator
    logic signed [31:0] cx_reg, cy_reg;
    logic signed [15:0] cz_reg;
    logic [3:0]         ci_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // input sort
    logic [CW-1:0] in_xmax, in_xmin, in_ymax, in_ymin, in_w, in_h;
    assign in_xmax = (s_data.corner_a_x > s_data.corner_b_x) ? s_data.corner_a_x
                                                              : s_data.corner_b_x;
    assign in_xmin = (s_data.corner_a_x > s_data.corner_b_x) ? s_data.corner_b_x
                                                              : s_data.corner_a_x;
    assign in_ymax = (s_data.corner_a_y > s_data.corner_b_y) ? s_data.corner_a_y
                                                              : s_data.corner_b_y;
    assign in_ymin = (s_data.corner_a_y > s_data.corner_b_y) ? s_data.corner_b_y
                                                              : s_data.corner_a_y;
    assign in_w = in_xmax - in_xmin;
    assign in_h = in_ymax - in_ymin;

    // edge operand select: right, left, bottom, top edge
    logic [CW-1:0] e_pos;
    logic [bbde_pkg::IMG_W-1:0] e_size;
    logic [bbde_pkg::FOV_W-1:0] e_fov;
    logic [CW:0] e_twice, e_size_x, e_d;
    logic        e_neg;
    always_comb begin
        case (edge_idx_reg)
            2'd0:    e_pos = xmax_reg;
            2'd1:    e_pos = xmin_reg;
            2'd2:    e_pos = ymax_reg;
            default: e_pos = ymin_reg;
        endcase
        e_size = edge_idx_reg[1] ? img_h_reg : img_w_reg;
        e_fov  = edge_idx_reg[1] ? fov_v_reg : fov_h_reg;
    end
    assign e_twice  = {e_pos, 1'b0};
    assign e_size_x = (CW+1)'(e_size);
    assign e_neg    = e_twice < e_size_x;
    assign e_d      = e_neg ? (e_size_x - e_twice) : (e_twice - e_size_x);

    // axis operand select
    logic [14:0]   a_min, a_max;
    logic [LB-1:0] a_len;
    assign a_min = axis_reg ? aymin_reg : axmin_reg;
    assign a_max = axis_reg ? aymax_reg : axmax_reg;
    assign a_len = axis_reg ? len_y_reg : len_x_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_full;
    always_comb begin
        if (state_reg == S_XMUL) begin
            mul_a = 32'(a_min);
            mul_b = 32'(a_len);
        end else begin
            mul_a = 32'(e_d);
            mul_b = 32'(e_fov);
        end
    end
    assign prod_full = {32'b0, mul_a} * {32'b0, mul_b};

    // divider step
    logic [DD:0]   dv_trial;
    logic          dv_ge;
    logic [DD-1:0] dv_rem_n;
    assign dv_trial = {dv_rem_reg, dv_quo_reg[DN-1]};
    assign dv_ge    = dv_trial >= {1'b0, dv_den_reg};
    assign dv_rem_n = dv_ge ? DD'(dv_trial - {1'b0, dv_den_reg}) : dv_trial[DD-1:0];

    // edge quotient post-processing
    logic [14:0] e_sat, e_clamp;
    assign e_sat   = (dv_quo_reg > DN'(bbde_pkg::ANG_SAT)) ? bbde_pkg::ANG_SAT
                                                            : dv_quo_reg[14:0];
    assign e_clamp = (dv_quo_reg > DN'(bbde_pkg::ANG_CLAMP)) ? bbde_pkg::ANG_CLAMP
                                                              : dv_quo_reg[14:0];

    // depth from quotient
    logic [DN-1:0] q_diff;
    logic [LB-1:0] q_depth;
    assign q_diff  = (dv_quo_reg >= DN'(focal_reg)) ? (dv_quo_reg - DN'(focal_reg))
                                                    : (DN'(focal_reg) - dv_quo_reg);
    assign q_depth = (q_diff > DN'(LEN_MAX)) ? LEN_MAX : q_diff[LB-1:0];

    // CORDIC step
    logic signed [31:0] c_xs, c_ys;
    logic signed [15:0] c_at;
    assign c_xs = cx_reg >>> ci_reg;
    assign c_ys = cy_reg >>> ci_reg;
    assign c_at = bbde_pkg::atan_q14(ci_reg);

    // decision
    logic [LB-1:0] d_diff, d_mean, d_larger;
    logic [LB+3:0] d_ten;
    logic [LB:0]   d_sum;
    logic          d_agree, d_border;
    assign d_diff   = (dx_reg > dy_reg) ? (dx_reg - dy_reg) : (dy_reg - dx_reg);
    assign d_ten    = ((LB+4)'(d_diff) << 3) + ((LB+4)'(d_diff) << 1);
    assign d_agree  = d_ten < (LB+4)'(dy_reg);
    assign d_sum    = (LB+1)'(dx_reg) + (LB+1)'(dy_reg);
    assign d_mean   = d_sum[LB:1];
    assign d_larger = (dx_reg > dy_reg) ? dx_reg : dy_reg;
    assign d_border = (xmax_reg == img_w_reg) || (xmin_reg == '0) ||
                      (ymax_reg == img_h_reg) || (ymin_reg == '0);

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // control, configuration and kept estimate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            last_est_reg <= '0;
            obj_w_reg    <= LB'(4096);
            obj_h_reg    <= LB'(4096);
            img_w_reg    <= 13'd640;
            img_h_reg    <= 13'd480;
            fov_h_reg    <= 16'd16384;
            fov_v_reg    <= 16'd12288;
            focal_reg    <= LB'(4096);
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    bbde_pkg::REG_OBJECT_WIDTH:  obj_w_reg <= cfg_wdata;
                    bbde_pkg::REG_OBJECT_HEIGHT: obj_h_reg <= cfg_wdata;
                    bbde_pkg::REG_IMAGE_WIDTH:   img_w_reg <= cfg_wdata[12:0];
                    bbde_pkg::REG_IMAGE_HEIGHT:  img_h_reg <= cfg_wdata[12:0];
                    bbde_pkg::REG_FOV_H:         fov_h_reg <= cfg_wdata[15:0];
                    bbde_pkg::REG_FOV_V:         fov_v_reg <= cfg_wdata[15:0];
                    bbde_pkg::REG_FOCAL:         focal_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // load a finished beat, else drop valid once the beat is taken
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= (img_w_reg == '0 || img_h_reg == '0) ? S_FIN : S_EMUL;
                    end
                end
                S_EMUL:  state_reg <= S_ELOAD;
                S_ELOAD: state_reg <= S_DIV;
                S_DIV: begin
                    if (dv_cnt_reg == '0) begin
                        case (op_reg)
                            OP_EDGE: state_reg <= (edge_idx_reg == 2'd3) ? S_CHECK : S_EMUL;
                            OP_X1:   state_reg <= S_CORD;
                            OP_TAN:  state_reg <= S_QLOAD;
                            default: state_reg <= axis_reg ? S_DECIDE : S_XMUL;
                        endcase
                    end
                end
                S_CHECK: begin
                    state_reg <= (axmin_reg == '0 || aymin_reg == '0) ? S_FIN : S_XMUL;
                end
                S_XMUL:  state_reg <= S_XLOAD;
                S_XLOAD: state_reg <= S_DIV;
                S_CORD: begin
                    if (ci_reg == 4'(bbde_pkg::CORD_STEPS - 1)) begin
                        state_reg <= S_TANCHK;
                    end
                end
                S_TANCHK: begin
                    state_reg <= (cx_reg <= 0 || cy_reg <= 0) ? S_QLOAD : S_DIV;
                end
                S_QLOAD:  state_reg <= S_DIV;
                S_DECIDE: state_reg <= S_FIN;
                S_FIN: begin
                    // hold until the output register is free, then hand the beat over
                    if (out_free) begin
                        if (upd_reg && !degen_reg) begin
                            last_est_reg <= dist_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (dv_cnt_reg != '0) begin
            dv_quo_reg <= {dv_quo_reg[DN-2:0], dv_ge};
            dv_rem_reg <= dv_rem_n;
            dv_cnt_reg <= dv_cnt_reg - 6'd1;
        end
        case (state_reg)
            S_IDLE: begin
                dv_cnt_reg <= '0;
                if (s_valid) begin
                    xmax_reg     <= in_xmax;
                    xmin_reg     <= in_xmin;
                    ymax_reg     <= in_ymax;
                    ymin_reg     <= in_ymin;
                    len_x_reg    <= (in_w > in_h) ? obj_h_reg : obj_w_reg;
                    len_y_reg    <= (in_h > in_w) ? obj_h_reg : obj_w_reg;
                    edge_idx_reg <= 2'd0;
                    axis_reg     <= 1'b0;
                    right_reg    <= '0;
                    left_reg     <= '0;
                    degen_reg    <= (img_w_reg == '0 || img_h_reg == '0);
                    upd_reg      <= 1'b0;
                    method_reg   <= bbde_pkg::METHOD_AGREE;
                    dist_reg     <= '0;
                end
            end
            S_EMUL: begin
                prod_reg <= prod_full[47:0];
                neg_reg  <= e_neg;
            end
            S_ELOAD: begin
                dv_quo_reg <= prod_reg + DN'(e_size);
                dv_den_reg <= DD'({e_size, 1'b0});
                dv_rem_reg <= '0;
                dv_cnt_reg <= 6'(DN);
                op_reg     <= OP_EDGE;
            end
            S_DIV: begin
                if (dv_cnt_reg == '0) begin
                    case (op_reg)
                        OP_EDGE: begin
                            case (edge_idx_reg)
                                2'd0: begin
                                    right_reg <= neg_reg ? -$signed({1'b0, e_sat})
                                                         : $signed({1'b0, e_sat});
                                    axmax_reg <= e_clamp;
                                end
                                2'd1: begin
                                    left_reg  <= neg_reg ? -$signed({1'b0, e_sat})
                                                         : $signed({1'b0, e_sat});
                                    axmin_reg <= e_clamp;
                                end
                                2'd2:    aymax_reg <= e_clamp;
                                default: aymin_reg <= e_clamp;
                            endcase
                            edge_idx_reg <= edge_idx_reg + 2'd1;
                        end
                        OP_X1: begin
                            x1_reg <= dv_quo_reg[LB-1:0];
                            cx_reg <= 32'sd1073741824;
                            cy_reg <= '0;
                            cz_reg <= $signed({1'b0, a_min});
                            ci_reg <= '0;
                        end
                        OP_TAN: begin
                            if (dv_quo_reg > DN'(32'hFFFF_FFFF)) begin
                                tan_reg <= 32'hFFFF_FFFF;
                            end else if (dv_quo_reg == '0) begin
                                tan_reg <= 32'd1;
                            end else begin
                                tan_reg <= dv_quo_reg[31:0];
                            end
                        end
                        default: begin
                            if (axis_reg) begin
                                dy_reg <= q_depth;
                            end else begin
                                dx_reg <= q_depth;
                            end
                            axis_reg <= 1'b1;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (axmin_reg == '0 || aymin_reg == '0) begin
                    degen_reg <= 1'b1;
                end
            end
            S_XMUL: begin
                prod_reg <= prod_full[47:0];
            end
            S_XLOAD: begin
                dv_quo_reg <= prod_reg;
                dv_den_reg <= DD'(a_min) + DD'(a_max);
                dv_rem_reg <= '0;
                dv_cnt_reg <= 6'(DN);
                op_reg     <= OP_X1;
            end
            S_CORD: begin
                if (cz_reg >= 0) begin
                    cx_reg <= cx_reg - c_ys;
                    cy_reg <= cy_reg + c_xs;
                    cz_reg <= cz_reg - c_at;
                end else begin
                    cx_reg <= cx_reg + c_ys;
                    cy_reg <= cy_reg - c_xs;
                    cz_reg <= cz_reg + c_at;
                end
                ci_reg <= ci_reg + 4'd1;
            end
            S_TANCHK: begin
                if (cx_reg <= 0) begin
                    tan_reg <= 32'hFFFF_FFFF;
                end else if (cy_reg <= 0) begin
                    tan_reg <= 32'd1;
                end else begin
                    dv_quo_reg <= DN'(cy_reg) << 16;
                    dv_den_reg <= DD'(cx_reg);
                    dv_rem_reg <= '0;
                    dv_cnt_reg <= 6'(DN);
                    op_reg     <= OP_TAN;
                end
            end
            S_QLOAD: begin
                dv_quo_reg <= DN'(x1_reg) << 16;
                dv_den_reg <= tan_reg;
                dv_rem_reg <= '0;
                dv_cnt_reg <= 6'(DN);
                op_reg     <= OP_Q;
            end
            S_DECIDE: begin
                if (dy_reg == '0) begin
                    degen_reg <= 1'b1;
                end else if (d_agree) begin
                    dist_reg   <= d_mean;
                    upd_reg    <= 1'b1;
                    method_reg <= bbde_pkg::METHOD_AGREE;
                end else if (d_border) begin
                    dist_reg   <= last_est_reg;
                    method_reg <= bbde_pkg::METHOD_BORDER;
                end else begin
                    dist_reg   <= d_larger;
                    upd_reg    <= 1'b1;
                    method_reg <= bbde_pkg::METHOD_LARGER;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    m_data_reg.distance     <= degen_reg ? '0 : 24'(dist_reg);
                    m_data_reg.out_of_range <= !degen_reg && (64'(dist_reg) > RANGE_LIMIT);
                    m_data_reg.degenerate   <= degen_reg;
                    m_data_reg.method       <= degen_reg ? bbde_pkg::METHOD_AGREE : method_reg;
                    m_data_reg.right_edge_angle <= right_reg;
                    m_data_reg.left_edge_angle  <= left_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_div_busy_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_cnt_reg != '0) |-> (state_reg == S_DIV))
        else $error("divider running outside its state");

    a_fin_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && out_free) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("finished item not delivered");

    a_degen_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.degenerate) |->
        (m_data_reg.distance == '0 && m_data_reg.method == bbde_pkg::METHOD_AGREE &&
         !m_data_reg.out_of_range))
        else $error("degenerate result carries a depth");

    a_est_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_est_reg != $past(last_est_reg)) |-> ($past(state_reg) == S_FIN))
        else $error("kept estimate changed outside delivery");
`endif

endmodule
